/* rtl/tilw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tilw_pkg
// Shared constants, types and the default weight table of the table
// interpolated log weight block.
// ----------------------------------------------------------------------------
package tilw_pkg;

    localparam int TABLE_DEPTH     = 16;
    localparam int TBL_AW          = $clog2(TABLE_DEPTH);
    localparam int NUM_DEFAULTS    = 11;

    localparam int WEIGHT_W        = 32;
    localparam int WEIGHT_FRAC     = 8;
    localparam int COS_W           = 18;
    localparam int MIN_W           = 17;
    localparam int BCNT_W          = 4;
    localparam int SCALE_W         = 24;
    localparam int INDEX_W         = 4;
    localparam int LOG_W           = 23;
    localparam int POS_W           = COS_W + SCALE_W;
    localparam int BIN_W           = POS_W - 32;
    localparam int FRAC_W          = 16;
    localparam int ACC_W           = FRAC_W + WEIGHT_W;
    localparam int LOG_FRAC_BITS   = 20;
    localparam int EXP_W           = 6;
    localparam int L2_W            = EXP_W + LOG_FRAC_BITS;
    localparam int MAG_W           = L2_W - 1;
    localparam int LN2_W           = 32;
    localparam int PROD_W          = MAG_W + LN2_W;
    localparam int RND_SHIFT       = 36;
    localparam int RND_W           = PROD_W - RND_SHIFT;

    localparam int CFG_DATA_W      = 24;
    localparam int CFG_IDX_W       = 2;

    localparam logic [LN2_W-1:0]    LN2_Q32      = 32'd2977044472;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 32'd256;
    localparam logic [MIN_W-1:0]    MIN_RESET    = 17'd6554;
    localparam logic [BCNT_W-1:0]   BCNT_RESET   = 4'd10;
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 24'd728178;

    typedef enum logic
    {
        KIND_WRITE  = 1'b0,
        KIND_LOOKUP = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_MIN_COS_ZEN = 2'd0,
        CFG_BIN_COUNT   = 2'd1,
        CFG_BIN_SCALE   = 2'd2
    } cfg_reg_t;

    typedef struct packed
    {
        logic [MIN_W-1:0]   min_cos_zen;
        logic [BCNT_W-1:0]  bin_count;
        logic [SCALE_W-1:0] bin_scale;
    } cfg_t;

    typedef struct packed
    {
        logic                en;
        logic                we;
        logic [TBL_AW-1:0]   waddr;
        logic [WEIGHT_W-1:0] wdata;
        logic [TBL_AW-1:0]   raddr0;
        logic [TBL_AW-1:0]   raddr1;
    } tbl_req_t;

    typedef struct packed
    {
        logic                query;
        logic [WEIGHT_W-1:0] weight;
    } wt_item_t;

    function automatic logic [WEIGHT_W-1:0] default_weight(input logic [TBL_AW-1:0] addr);
        logic [WEIGHT_W-1:0] w;
        case (int'(addr))
            0:       w = 32'd256;
            1:       w = 32'd51200;
            2:       w = 32'd1280000;
            3:       w = 32'd12800000;
            4:       w = 32'd25600000;
            5:       w = 32'd51200000;
            6:       w = 32'd102400000;
            7:       w = 32'd128000000;
            8:       w = 32'd153600000;
            9:       w = 32'd204800000;
            10:      w = 32'd230400000;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* rtl/tilw_chan_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tilw_chan_if
// Request and result channels of the table interpolated log weight block.
// ----------------------------------------------------------------------------
interface tilw_query_if;
    import tilw_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic [INDEX_W-1:0]  entry_index;
    logic [WEIGHT_W-1:0] entry_value;
    logic signed [COS_W-1:0] cos_zenith;

    modport source (output valid, kind, entry_index, entry_value, cos_zenith, input ready);
    modport sink   (input valid, kind, entry_index, entry_value, cos_zenith, output ready);
endinterface

interface tilw_result_if;
    import tilw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [WEIGHT_W-1:0]     weight;
    logic signed [LOG_W-1:0] log_weight;
    logic                    zero_weight;

    modport source (output valid, weight, log_weight, zero_weight, input ready);
    modport sink   (input valid, weight, log_weight, zero_weight, output ready);
endinterface
`default_nettype wire

/* rtl/tilw_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tilw_table
// Weight table memory: one write port, two registered read ports. Entries
// never written read as their default weight.
// ----------------------------------------------------------------------------
module tilw_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tilw_pkg::tbl_req_t            req,
    output logic [tilw_pkg::WEIGHT_W-1:0]      rdata0,
    output logic [tilw_pkg::WEIGHT_W-1:0]      rdata1
);
    import tilw_pkg::*;

    logic [WEIGHT_W-1:0]    weight_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] written_reg;
    logic [WEIGHT_W-1:0]    mem0_reg;
    logic [WEIGHT_W-1:0]    mem1_reg;
    logic [WEIGHT_W-1:0]    dflt0_reg;
    logic [WEIGHT_W-1:0]    dflt1_reg;
    logic                   hit0_reg;
    logic                   hit1_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            weight_mem[req.waddr] <= req.wdata;
        end
        if (req.en)
        begin
            mem0_reg  <= weight_mem[req.raddr0];
            mem1_reg  <= weight_mem[req.raddr1];
            dflt0_reg <= default_weight(req.raddr0);
            dflt1_reg <= default_weight(req.raddr1);
            hit0_reg  <= written_reg[req.raddr0];
            hit1_reg  <= written_reg[req.raddr1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (req.we)
        begin
            written_reg[req.waddr] <= 1'b1;
        end
    end

    assign rdata0 = hit0_reg ? mem0_reg : dflt0_reg;
    assign rdata1 = hit1_reg ? mem1_reg : dflt1_reg;

endmodule
`default_nettype wire

/* rtl/tilw_interp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tilw_interp
// Bin position, table access and linear blend: six stages with per-stage
// valid and a ready chain that closes bubbles.
// ----------------------------------------------------------------------------
module tilw_interp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tilw_pkg::cfg_t       cfg,
    tilw_query_if.sink                query,
    output logic                      dn_valid,
    input  wire logic                 dn_ready,
    output tilw_pkg::wt_item_t        dn_data
);
    import tilw_pkg::*;

    localparam logic [FRAC_W:0] FRAC_ONE  = 17'd65536;
    localparam logic [ACC_W-1:0] ACC_HALF = 48'd32768;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, s6_ready;

    logic [COS_W:0]       diff;
    logic                 below;

    logic                 s1_query_reg;
    logic [INDEX_W-1:0]   s1_idx_reg;
    logic [WEIGHT_W-1:0]  s1_value_reg;
    logic                 s1_below_reg;
    logic [COS_W-1:0]     s1_diff_reg;

    logic                 s2_query_reg;
    logic [INDEX_W-1:0]   s2_idx_reg;
    logic [WEIGHT_W-1:0]  s2_value_reg;
    logic                 s2_below_reg;
    logic [POS_W-1:0]     s2_pos_reg;

    logic [BIN_W-1:0]     bin;
    logic [FRAC_W-1:0]    frac;
    logic [TBL_AW-1:0]    last;
    logic                 use_last;
    logic [FRAC_W-1:0]    frac_eff;
    tbl_req_t             tbl_req;
    logic [WEIGHT_W-1:0]  rdata0;
    logic [WEIGHT_W-1:0]  rdata1;

    logic                 s3_query_reg;
    logic [FRAC_W-1:0]    s3_frac_reg;

    logic                 s4_query_reg;
    logic [FRAC_W-1:0]    s4_frac_reg;
    logic [ACC_W-1:0]     s4_p0_reg;
    logic [WEIGHT_W-1:0]  s4_t1_reg;

    logic                 s5_query_reg;
    logic [ACC_W-1:0]     s5_acc_reg;

    logic                 s6_query_reg;
    logic [WEIGHT_W-1:0]  s6_weight_reg;
    logic [ACC_W-1:0]     rounded;

    assign s6_ready    = !s6_valid_reg || dn_ready;
    assign s5_ready    = !s5_valid_reg || s6_ready;
    assign s4_ready    = !s4_valid_reg || s5_ready;
    assign s3_ready    = !s3_valid_reg || s4_ready;
    assign s2_ready    = !s2_valid_reg || s3_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign query.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= query.valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
            if (s5_ready) s5_valid_reg <= s4_valid_reg;
            if (s6_ready) s6_valid_reg <= s5_valid_reg;
        end
    end

    // distance above the lowest covered cosine
    assign diff  = {query.cos_zenith[COS_W-1], query.cos_zenith}
                 - {{(COS_W+1-MIN_W){cfg.min_cos_zen[MIN_W-1]}}, cfg.min_cos_zen};
    assign below = diff[COS_W] || (diff == '0);

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_query_reg <= (query.kind == KIND_LOOKUP);
            s1_idx_reg   <= query.entry_index;
            s1_value_reg <= query.entry_value;
            s1_below_reg <= below;
            s1_diff_reg  <= diff[COS_W-1:0];
        end
        if (s2_ready)
        begin
            s2_query_reg <= s1_query_reg;
            s2_idx_reg   <= s1_idx_reg;
            s2_value_reg <= s1_value_reg;
            s2_below_reg <= s1_below_reg;
            s2_pos_reg   <= s1_diff_reg * cfg.bin_scale;
        end
    end

    assign bin  = s2_pos_reg[POS_W-1:32];
    assign frac = s2_pos_reg[31:16];

    always_comb
    begin
        if (32'(cfg.bin_count) > TABLE_DEPTH - 1)
        begin
            last = TBL_AW'(TABLE_DEPTH - 1);
        end
        else
        begin
            last = TBL_AW'(cfg.bin_count);
        end
        use_last = 32'(bin) >= 32'(last);

        tbl_req.en    = s3_ready;
        tbl_req.we    = s2_valid_reg && s3_ready && !s2_query_reg
                     && (32'(s2_idx_reg) < TABLE_DEPTH);
        tbl_req.waddr = TBL_AW'(s2_idx_reg);
        tbl_req.wdata = s2_value_reg;

        if (s2_below_reg)
        begin
            tbl_req.raddr0 = '0;
            tbl_req.raddr1 = '0;
            frac_eff       = '0;
        end
        else if (use_last)
        begin
            tbl_req.raddr0 = last;
            tbl_req.raddr1 = last;
            frac_eff       = '0;
        end
        else
        begin
            tbl_req.raddr0 = TBL_AW'(bin);
            tbl_req.raddr1 = TBL_AW'(bin) + TBL_AW'(1);
            frac_eff       = frac;
        end
    end

    tilw_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (tbl_req),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    assign rounded = s5_acc_reg + ACC_HALF;

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_query_reg <= s2_query_reg;
            s3_frac_reg  <= frac_eff;
        end
        if (s4_ready)
        begin
            s4_query_reg <= s3_query_reg;
            s4_frac_reg  <= s3_frac_reg;
            s4_p0_reg    <= (FRAC_ONE - {1'b0, s3_frac_reg}) * rdata0;
            s4_t1_reg    <= rdata1;
        end
        if (s5_ready)
        begin
            s5_query_reg <= s4_query_reg;
            s5_acc_reg   <= s4_p0_reg + s4_frac_reg * s4_t1_reg;
        end
        if (s6_ready)
        begin
            s6_query_reg  <= s5_query_reg;
            s6_weight_reg <= s5_query_reg ? rounded[ACC_W-1:FRAC_W] : '0;
        end
    end

    assign dn_valid       = s6_valid_reg;
    assign dn_data.query  = s6_query_reg;
    assign dn_data.weight = s6_weight_reg;

endmodule
`default_nettype wire

/* rtl/tilw_log.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tilw_log
// Fixed-point natural log: leading-one search, normalise, twenty squaring
// stages for the log2 fraction, then scale by ln 2 and round.
// ----------------------------------------------------------------------------
module tilw_log (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire tilw_pkg::wt_item_t   up_data,
    tilw_result_if.source             result
);
    import tilw_pkg::*;

    localparam int SQ_N = LOG_FRAC_BITS;
    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (RND_SHIFT - 1);

    logic                 l1_valid_reg, l2_valid_reg;
    logic                 l1_ready, l2_ready;
    logic [3:0]           nz;
    logic [2:0]           pos [4];

    logic                 l1_query_reg;
    logic [WEIGHT_W-1:0]  l1_weight_reg;
    logic [3:0]           l1_nz_reg;
    logic [2:0]           l1_pos_reg [4];

    logic [4:0]           top_bit;
    logic                 l2_query_reg;
    logic                 l2_zero_reg;
    logic [WEIGHT_W-1:0]  l2_weight_reg;
    logic [31:0]          l2_x_reg;
    logic [EXP_W-1:0]     l2_exp_reg;

    logic                 sq_valid_reg  [SQ_N];
    logic                 sq_query_reg  [SQ_N];
    logic                 sq_zero_reg   [SQ_N];
    logic [WEIGHT_W-1:0]  sq_weight_reg [SQ_N];
    logic [31:0]          sq_x_reg      [SQ_N];
    logic [EXP_W-1:0]     sq_exp_reg    [SQ_N];
    logic [LOG_FRAC_BITS-1:0] sq_frac_reg [SQ_N];

    logic                 sq_rdy   [SQ_N+1];
    logic                 src_valid [SQ_N];
    logic [31:0]          src_x    [SQ_N];
    logic [LOG_FRAC_BITS-1:0] src_frac [SQ_N];
    logic [31:0]          nxt_x    [SQ_N];
    logic [LOG_FRAC_BITS-1:0] nxt_frac [SQ_N];

    logic                 f1_valid_reg, f2_valid_reg, f3_valid_reg;
    logic                 f1_ready, f2_ready, f3_ready;
    logic [L2_W-1:0]      l2_val;
    logic [L2_W-1:0]      l2_abs;

    logic                 f1_kill_reg, f1_flag_reg, f1_neg_reg;
    logic [WEIGHT_W-1:0]  f1_weight_reg;
    logic [MAG_W-1:0]     f1_mag_reg;

    logic                 f2_kill_reg, f2_flag_reg, f2_neg_reg;
    logic [WEIGHT_W-1:0]  f2_weight_reg;
    logic [PROD_W-1:0]    f2_prod_reg;

    logic [PROD_W-1:0]    rsum;
    logic [LOG_W-1:0]     rmag;
    logic                 f3_flag_reg;
    logic [WEIGHT_W-1:0]  f3_weight_reg;
    logic [LOG_W-1:0]     f3_log_reg;

    // ready chain, back to front
    assign f3_ready = !f3_valid_reg || result.ready;
    assign f2_ready = !f2_valid_reg || f3_ready;
    assign f1_ready = !f1_valid_reg || f2_ready;

    always_comb
    begin
        sq_rdy[SQ_N] = f1_ready;
        for (int k = SQ_N - 1; k >= 0; k--)
        begin
            sq_rdy[k] = !sq_valid_reg[k] || sq_rdy[k+1];
        end
    end

    assign l2_ready = !l2_valid_reg || sq_rdy[0];
    assign l1_ready = !l1_valid_reg || l2_ready;
    assign up_ready = l1_ready;

    // per-byte leading-one position
    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            nz[b]  = |up_data.weight[8*b +: 8];
            pos[b] = '0;
            for (int i = 0; i < 8; i++)
            begin
                if (up_data.weight[8*b + i])
                begin
                    pos[b] = 3'(i);
                end
            end
        end
    end

    always_comb
    begin
        if (l1_nz_reg[3])
        begin
            top_bit = {2'd3, l1_pos_reg[3]};
        end
        else if (l1_nz_reg[2])
        begin
            top_bit = {2'd2, l1_pos_reg[2]};
        end
        else if (l1_nz_reg[1])
        begin
            top_bit = {2'd1, l1_pos_reg[1]};
        end
        else
        begin
            top_bit = {2'd0, l1_pos_reg[0]};
        end
    end

    // one truncated squaring per stage
    always_comb
    begin
        logic [63:0] prod;
        logic [32:0] y;
        prod = '0;
        y    = '0;
        for (int k = 0; k < SQ_N; k++)
        begin
            if (k == 0)
            begin
                src_valid[k] = l2_valid_reg;
                src_x[k]     = l2_x_reg;
                src_frac[k]  = '0;
            end
            else
            begin
                src_valid[k] = sq_valid_reg[k-1];
                src_x[k]     = sq_x_reg[k-1];
                src_frac[k]  = sq_frac_reg[k-1];
            end
            prod        = {32'b0, src_x[k]} * {32'b0, src_x[k]};
            y           = prod[63:31];
            nxt_x[k]    = y[32] ? y[32:1] : y[31:0];
            nxt_frac[k] = src_frac[k];
            nxt_frac[k][LOG_FRAC_BITS-1-k] = y[32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_valid_reg <= 1'b0;
            l2_valid_reg <= 1'b0;
            for (int k = 0; k < SQ_N; k++)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else
        begin
            if (l1_ready) l1_valid_reg <= up_valid;
            if (l2_ready) l2_valid_reg <= l1_valid_reg;
            for (int k = 0; k < SQ_N; k++)
            begin
                if (sq_rdy[k]) sq_valid_reg[k] <= src_valid[k];
            end
            if (f1_ready) f1_valid_reg <= sq_valid_reg[SQ_N-1];
            if (f2_ready) f2_valid_reg <= f1_valid_reg;
            if (f3_ready) f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (l1_ready)
        begin
            l1_query_reg  <= up_data.query;
            l1_weight_reg <= up_data.weight;
            l1_nz_reg     <= nz;
            for (int b = 0; b < 4; b++)
            begin
                l1_pos_reg[b] <= pos[b];
            end
        end
        if (l2_ready)
        begin
            l2_query_reg  <= l1_query_reg;
            l2_zero_reg   <= ~|l1_nz_reg;
            l2_weight_reg <= l1_weight_reg;
            l2_x_reg      <= l1_weight_reg << (~top_bit);
            l2_exp_reg    <= EXP_W'(top_bit) - EXP_W'(WEIGHT_FRAC);
        end
        for (int k = 0; k < SQ_N; k++)
        begin
            if (sq_rdy[k])
            begin
                sq_x_reg[k]    <= nxt_x[k];
                sq_frac_reg[k] <= nxt_frac[k];
                if (k == 0)
                begin
                    sq_query_reg[k]  <= l2_query_reg;
                    sq_zero_reg[k]   <= l2_zero_reg;
                    sq_weight_reg[k] <= l2_weight_reg;
                    sq_exp_reg[k]    <= l2_exp_reg;
                end
                else
                begin
                    sq_query_reg[k]  <= sq_query_reg[k-1];
                    sq_zero_reg[k]   <= sq_zero_reg[k-1];
                    sq_weight_reg[k] <= sq_weight_reg[k-1];
                    sq_exp_reg[k]    <= sq_exp_reg[k-1];
                end
            end
        end
    end

    assign l2_val = {sq_exp_reg[SQ_N-1], sq_frac_reg[SQ_N-1]};
    assign l2_abs = l2_val[L2_W-1] ? (~l2_val + L2_W'(1)) : l2_val;
    assign rsum   = f2_prod_reg + RND_HALF;
    assign rmag   = LOG_W'(rsum[PROD_W-1:RND_SHIFT]);

    always_ff @(posedge clk)
    begin
        if (f1_ready)
        begin
            f1_kill_reg   <= !sq_query_reg[SQ_N-1] || sq_zero_reg[SQ_N-1];
            f1_flag_reg   <= sq_query_reg[SQ_N-1] && sq_zero_reg[SQ_N-1];
            f1_neg_reg    <= l2_val[L2_W-1];
            f1_weight_reg <= sq_weight_reg[SQ_N-1];
            f1_mag_reg    <= l2_abs[MAG_W-1:0];
        end
        if (f2_ready)
        begin
            f2_kill_reg   <= f1_kill_reg;
            f2_flag_reg   <= f1_flag_reg;
            f2_neg_reg    <= f1_neg_reg;
            f2_weight_reg <= f1_weight_reg;
            f2_prod_reg   <= f1_mag_reg * LN2_Q32;
        end
        if (f3_ready)
        begin
            f3_flag_reg   <= f2_flag_reg;
            f3_weight_reg <= f2_weight_reg;
            if (f2_kill_reg)
            begin
                f3_log_reg <= '0;
            end
            else if (f2_neg_reg)
            begin
                f3_log_reg <= ~rmag + LOG_W'(1);
            end
            else
            begin
                f3_log_reg <= rmag;
            end
        end
    end

    assign result.valid       = f3_valid_reg;
    assign result.weight      = f3_weight_reg;
    assign result.log_weight  = f3_log_reg;
    assign result.zero_weight = f3_flag_reg;

endmodule
`default_nettype wire

/* rtl/table_interp_log_weight.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// table_interp_log_weight
// Log of a weight interpolated from a loadable table over cosine of zenith.
//
// Requests arrive on the query channel (valid/ready). A request of kind
// write stores entry_value in table entry entry_index and returns a result
// of all zeros; a request of kind lookup returns the interpolated weight
// (Q24.8), its natural log (Q6.16) and a flag for a zero weight. Every
// request gives exactly one result on the result channel, in order.
// One request is taken per clock while the result side does not stall. Each
// lookup reads both neighbouring entries in the same cycle through the two
// read ports of the table memory, and a write lands in the table at that same
// stage, so later lookups see it.
// The user must write the three registers through cfg_we/cfg_index/cfg_wdata
// only while no request is in flight; the block does not enforce it. Reset
// restores their defaults and makes the table read back its default weights
// until entries are written. When the result receiver stalls, results back up
// stage by stage; empty stages keep taking requests until the pipeline is full.
// ----------------------------------------------------------------------------
module table_interp_log_weight (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [tilw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tilw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    tilw_query_if.sink                              query,
    tilw_result_if.source                           result
);
    import tilw_pkg::*;

    logic [MIN_W-1:0]   min_cos_zen_reg;
    logic [BCNT_W-1:0]  bin_count_reg;
    logic [SCALE_W-1:0] bin_scale_reg;
    cfg_t               cfg;
    logic               wt_valid;
    logic               wt_ready;
    wt_item_t           wt_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_cos_zen_reg <= MIN_RESET;
            bin_count_reg   <= BCNT_RESET;
            bin_scale_reg   <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_MIN_COS_ZEN: min_cos_zen_reg <= cfg_wdata[MIN_W-1:0];
                CFG_BIN_COUNT:   bin_count_reg   <= cfg_wdata[BCNT_W-1:0];
                CFG_BIN_SCALE:   bin_scale_reg   <= cfg_wdata[SCALE_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg.min_cos_zen = min_cos_zen_reg;
    assign cfg.bin_count   = bin_count_reg;
    assign cfg.bin_scale   = bin_scale_reg;

    tilw_interp u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .query    (query),
        .dn_valid (wt_valid),
        .dn_ready (wt_ready),
        .dn_data  (wt_data)
    );

    tilw_log u_log (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (wt_valid),
        .up_ready (wt_ready),
        .up_data  (wt_data),
        .result   (result)
    );

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.zero_weight
        |-> result.log_weight == '0 && result.weight == '0)
        else $error("zero weight flagged with non-zero log or weight");

    a_log_pos: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.weight >= WEIGHT_ONE
        |-> !result.log_weight[LOG_W-1])
        else $error("negative log for weight of one or more");

    a_log_neg: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.weight != '0 && result.weight < WEIGHT_ONE
        |-> result.log_weight[LOG_W-1])
        else $error("non-negative log for weight below one");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the table interpolated log weight block. A short
// table of directed requests is followed by random requests under several
// register settings. Every result is compared field by field with a fixed
// outcome from the table or an in-bench prediction of the interpolated
// weight and its Q6.16 logarithm, while both channels idle at random and the
// result side stalls for long stretches.
// ----------------------------------------------------------------------------
module testbench;
    import tilw_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 300000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int CHOKE_CYCLES   = 200;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_REQUESTS = 300;
    localparam int DIRECTED_ROWS  = 22;

    localparam logic [63:0] LN2_SCALED = 64'd2977044472;

    typedef struct packed
    {
        kind_t                   kind;
        logic [INDEX_W-1:0]      index;
        logic [WEIGHT_W-1:0]     value;
        logic signed [COS_W-1:0] cos;
    } request_t;

    typedef struct packed
    {
        logic [WEIGHT_W-1:0] weight;
        logic [LOG_W-1:0]    log_weight;
        logic                zero_weight;
    } outcome_t;

    typedef struct packed
    {
        request_t rq;
        logic     fixed;
        outcome_t out;
    } row_t;

    localparam outcome_t ZERO_OUT  = '{32'd0, 23'd0, 1'b0};
    localparam outcome_t UNIT_OUT  = '{32'd256, 23'd0, 1'b0};
    localparam outcome_t EMPTY_OUT = '{32'd0, 23'd0, 1'b1};

    localparam logic [WEIGHT_W-1:0] FACTORY_WEIGHTS [11] = '{
        32'd256, 32'd51200, 32'd1280000, 32'd12800000, 32'd25600000, 32'd51200000,
        32'd102400000, 32'd128000000, 32'd153600000, 32'd204800000, 32'd230400000
    };

    row_t directed [DIRECTED_ROWS] = '{
        '{'{KIND_LOOKUP, 4'h0, 32'h0000_0000, 18'h20000},     1'b1, UNIT_OUT},
        '{'{KIND_LOOKUP, 4'hF, 32'hFFFF_FFFF, -18'sd65536},   1'b1, UNIT_OUT},
        '{'{KIND_LOOKUP, 4'h0, 32'h0000_0000, 18'sd6554},     1'b1, UNIT_OUT},
        '{'{KIND_LOOKUP, 4'h0, 32'h0000_0000, 18'sd6555},     1'b0, ZERO_OUT},
        '{'{KIND_LOOKUP, 4'h0, 32'h0000_0000, 18'sd32768},    1'b0, ZERO_OUT},
        '{'{KIND_LOOKUP, 4'h0, 32'h0000_0000, 18'sd65536},    1'b0, ZERO_OUT},
        '{'{KIND_LOOKUP, 4'h0, 32'h0000_0000, 18'h1FFFF},     1'b0, ZERO_OUT},
        '{'{KIND_WRITE,  4'h0, 32'h0000_0000, 18'h3FFFF},     1'b1, ZERO_OUT},
        '{'{KIND_LOOKUP, 4'h0, 32'h0000_0000, 18'h20000},     1'b1, EMPTY_OUT},
        '{'{KIND_WRITE,  4'hF, 32'hFFFF_FFFF, 18'h00000},     1'b1, ZERO_OUT},
        '{'{KIND_WRITE,  4'h0, 32'hFFFF_FFFF, 18'h00000},     1'b1, ZERO_OUT},
        '{'{KIND_LOOKUP, 4'h0, 32'h0000_0000, 18'sd0},        1'b0, ZERO_OUT},
        '{'{KIND_WRITE,  4'h0, 32'h0000_0001, 18'h00000},     1'b1, ZERO_OUT},
        '{'{KIND_LOOKUP, 4'h0, 32'h0000_0000, -18'sd1},       1'b0, ZERO_OUT},
        '{'{KIND_WRITE,  4'hA, 32'hAAAA_AAAA, 18'h2AAAA},     1'b1, ZERO_OUT},
        '{'{KIND_WRITE,  4'h5, 32'h5555_5555, 18'h15555},     1'b1, ZERO_OUT},
        '{'{KIND_LOOKUP, 4'h0, 32'h0000_0000, 18'h1FFFF},     1'b0, ZERO_OUT},
        '{'{KIND_LOOKUP, 4'h0, 32'h0000_0000, 18'sd60000},    1'b0, ZERO_OUT},
        '{'{KIND_WRITE,  4'h0, 32'd256,       18'h00000},     1'b1, ZERO_OUT},
        '{'{KIND_WRITE,  4'hA, 32'd230400000, 18'h00000},     1'b1, ZERO_OUT},
        '{'{KIND_LOOKUP, 4'h0, 32'h0000_0000, 18'sd40000},    1'b0, ZERO_OUT},
        '{'{KIND_LOOKUP, 4'h0, 32'h0000_0000, 18'sd6553},     1'b1, UNIT_OUT}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    tilw_query_if  query_ch ();
    tilw_result_if result_ch ();

    table_interp_log_weight uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .query     (query_ch),
        .result    (result_ch)
    );

    logic [WEIGHT_W-1:0]     entry_mem [TABLE_DEPTH];
    logic signed [MIN_W-1:0] lo_cos;
    logic [BCNT_W-1:0]       bin_cnt;
    logic [SCALE_W-1:0]      bins_per_unit;

    outcome_t pending_outcomes [$];
    outcome_t expected_out;
    int       fail_count = 0;
    int       burst_left = 0;
    bit       choke_req = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic restore_defaults();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            entry_mem[i] = (i < 11) ? FACTORY_WEIGHTS[i] : '0;
        end
        lo_cos        = 17'sd6554;
        bin_cnt       = 4'd10;
        bins_per_unit = 24'd728178;
    endtask

    function automatic logic [WEIGHT_W-1:0] interp_weight(logic signed [COS_W-1:0] cosv);
        longint      minv;
        int          last;
        logic [63:0] pos;
        logic [63:0] bin;
        logic [63:0] frac;
        logic [63:0] acc;
        minv = longint'(lo_cos);
        last = int'(bin_cnt);
        if (last > TABLE_DEPTH - 1)
            last = TABLE_DEPTH - 1;
        if (longint'(cosv) <= minv)
            return entry_mem[0];
        pos  = 64'(longint'(cosv) - minv) * 64'(bins_per_unit);
        bin  = pos >> 32;
        frac = (pos >> 16) & 64'hFFFF;
        if (bin >= 64'(last))
            return entry_mem[last];
        acc = (64'd65536 - frac) * 64'(entry_mem[int'(bin)])
            + frac * 64'(entry_mem[int'(bin) + 1]);
        return 32'((acc + 64'd32768) >> 16);
    endfunction

    function automatic logic [LOG_W-1:0] ln_q16(logic [WEIGHT_W-1:0] w);
        int          p;
        logic [63:0] x;
        logic [63:0] mag;
        longint      l2;
        bit          neg;
        p = 31;
        while (p > 0 && !w[p])
            p--;
        x  = 64'(w) << (31 - p);
        l2 = longint'(p - 8) * 1048576;
        for (int k = 0; k < 20; k++)
        begin
            x = (x * x) >> 31;
            if (x >= 64'h1_0000_0000)
            begin
                x  = x >> 1;
                l2 += longint'(1) << (19 - k);
            end
        end
        neg = (l2 < 0);
        mag = 64'(neg ? -l2 : l2) * LN2_SCALED;
        mag = (mag + (64'd1 << 35)) >> 36;
        return neg ? 23'(-mag) : 23'(mag);
    endfunction

    function automatic outcome_t apply_request(request_t rq);
        outcome_t o;
        logic [WEIGHT_W-1:0] w;
        o = ZERO_OUT;
        if (rq.kind == KIND_WRITE)
        begin
            entry_mem[rq.index] = rq.value;
            return o;
        end
        w = interp_weight(rq.cos);
        o.weight = w;
        if (w == '0)
            o.zero_weight = 1'b1;
        else
            o.log_weight = ln_q16(w);
        return o;
    endfunction

    function automatic request_t random_request();
        request_t rq;
        int       r;
        int       b;
        longint   off;
        longint   c;
        rq.kind  = KIND_LOOKUP;
        rq.index = 4'($urandom_range(0, 15));
        rq.value = $urandom;
        rq.cos   = 18'($urandom);
        if ($urandom_range(0, 99) < 22)
        begin
            rq.kind = KIND_WRITE;
            if ($urandom_range(0, 9) < 7)
                rq.index = 4'($urandom_range(0, int'(bin_cnt)));
            case ($urandom_range(0, 9))
                0:       rq.value = '0;
                1:       rq.value = 32'($urandom_range(1, 255));
                2:       rq.value = 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
                default: rq.value = $urandom;
            endcase
            return rq;
        end
        r = $urandom_range(0, 99);
        c = longint'(lo_cos);
        if (r < 60)
            c = c + longint'($urandom_range(0, 65536 - int'(lo_cos)));
        else if (r < 70)
            c = c + longint'($urandom_range(0, 2)) - 1;
        else if (r < 80)
            c = longint'(rq.cos);
        else if (bins_per_unit != '0)
        begin
            b   = $urandom_range(0, int'(bin_cnt));
            off = (longint'(b) << 32) / longint'(bins_per_unit);
            c   = c + off + longint'($urandom_range(0, 2)) - 1;
        end
        else
            c = ($urandom_range(0, 1) != 0) ? 65536 : -65536;
        if (c > 131071)
            c = 131071;
        rq.cos = 18'(c);
        return rq;
    endfunction

    task automatic issue_request(request_t rq, bit fixed, outcome_t fixed_out);
        outcome_t predicted;
        int       gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            repeat (gap)
            begin
                @(negedge clk);
                query_ch.valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        @(negedge clk);
        query_ch.valid       <= 1'b1;
        query_ch.kind        <= rq.kind;
        query_ch.entry_index <= rq.index;
        query_ch.entry_value <= rq.value;
        query_ch.cos_zenith  <= rq.cos;
        @(posedge clk);
        while (!query_ch.ready)
            @(posedge clk);
        predicted = apply_request(rq);
        pending_outcomes.push_back(fixed ? fixed_out : predicted);
        burst_left--;
    endtask

    task automatic await_idle();
        @(negedge clk);
        query_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_MIN_COS_ZEN: lo_cos        = data[MIN_W-1:0];
            CFG_BIN_COUNT:   bin_cnt       = data[BCNT_W-1:0];
            CFG_BIN_SCALE:   bins_per_unit = data[SCALE_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic program_phase(int phase);
        int     m;
        int     bc;
        longint sc;
        case (phase)
            0:
            begin
                m  = 6554;
                bc = 10;
                sc = 728178;
            end
            1:
            begin
                m  = -65536;
                bc = 15;
                sc = 491520;
            end
            2:
            begin
                m  = 65535;
                bc = 1;
                sc = 16777215;
            end
            3:
            begin
                m  = 0;
                bc = 0;
                sc = 0;
            end
            4:
            begin
                m  = $urandom_range(0, 125536) - 65536;
                bc = $urandom_range(1, 15);
                sc = (longint'(bc) << 32) / longint'(65536 - m);
            end
            default:
            begin
                m  = $urandom_range(0, 131071) - 65536;
                bc = $urandom_range(0, 15);
                sc = longint'($urandom & 32'h00FF_FFFF);
            end
        endcase
        program_register(CFG_MIN_COS_ZEN, {7'd0, 17'(m)});
        program_register(CFG_BIN_COUNT, 24'(bc));
        program_register(CFG_BIN_SCALE, 24'(sc));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result with no request outstanding: weight %0d log_weight %0d",
                       result_ch.weight, $signed(result_ch.log_weight));
                fail_count++;
            end
            else
            begin
                expected_out = pending_outcomes.pop_front();
                if (result_ch.weight !== expected_out.weight)
                begin
                    $error("weight: expected %0d, got %0d",
                           expected_out.weight, result_ch.weight);
                    fail_count++;
                end
                if (result_ch.log_weight !== expected_out.log_weight)
                begin
                    $error("log_weight: expected %0d, got %0d",
                           $signed(expected_out.log_weight), $signed(result_ch.log_weight));
                    fail_count++;
                end
                if (result_ch.zero_weight !== expected_out.zero_weight)
                begin
                    $error("zero_weight: expected %0b, got %0b",
                           expected_out.zero_weight, result_ch.zero_weight);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : receiver
        int mode;
        int mode_left;
        int held;
        result_ch.ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        held      = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (choke_req)
            begin
                result_ch.ready <= 1'b0;
                held++;
                if (held == CHOKE_CYCLES)
                begin
                    choke_req = 1'b0;
                    held      = 0;
                end
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    2:       result_ch.ready <= (mode_left % 4 == 0);
                    default: result_ch.ready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    initial
    begin
        #(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        query_ch.valid       = 1'b0;
        query_ch.kind        = KIND_WRITE;
        query_ch.entry_index = '0;
        query_ch.entry_value = '0;
        query_ch.cos_zenith  = '0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_MIN_COS_ZEN;
        cfg_wdata            = '0;
        restore_defaults();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            issue_request(directed[i].rq, directed[i].fixed, directed[i].out);
        end
        await_idle();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            program_phase(phase);
            // hold the result side off so that the pipeline fills and backs up
            if (phase == 1 || phase == 4)
                choke_req = 1'b1;
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                issue_request(random_request(), 1'b0, ZERO_OUT);
            end
            await_idle();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
